[src/disjoint_set_union_find_macros.svh]
// assertion macros shared by the union-find block
`ifndef DISJOINT_SET_UNION_FIND_MACROS_SVH
`define DISJOINT_SET_UNION_FIND_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define DSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/dsu_pkg.sv]
// types and codes for the union-find block
`timescale 1ns / 1ps

package dsu_pkg;

  // element index and set count as carried on the ports
  typedef logic [9:0]  elem_t;
  typedef logic [10:0] cnt_t;

  // request codes; code three behaves as a connected query
  typedef enum logic [1:0] {
    REQ_FIND  = 2'd0,
    REQ_MERGE = 2'd1,
    REQ_CONN  = 2'd2,
    REQ_CONN3 = 2'd3
  } req_type_t;

  // input item
  typedef struct packed {
    req_type_t req_type;
    elem_t     elem_x;
    elem_t     elem_y;
  } in_t;

  // result item
  typedef struct packed {
    elem_t root_x;
    elem_t root_y;
    logic  same_set;
    logic  did_merge;
    cnt_t  set_count;
    logic  bad_index;
  } out_t;

  // largest element count the index fields can reach
  localparam int unsigned MAX_INDEXED = 1024;

endpackage

[src/disjoint_set_union_find.sv]
// union-find block: parent table memory, walk/compress sequencer and result register
// Channels: the input channel (in_valid, in_ready, in_data) carries a request
// item: find root of elem_x, merge elem_x with elem_y, or test whether both are
// connected. The result channel (out_valid, out_ready, out_data) returns one
// item per request with both roots, the same-set and merged flags, the live
// set count and an out-of-range flag. cfg_we/cfg_wdata write the element count
// and restart the forest as singletons.
// The idle state takes a request; the walk state follows parent links from
// elem_x to its root and the compress state points each node on that path at
// the root, then elem_y is done alike (find skips it). An out-of-range request
// goes straight to the final state, which links the roots of a merge and loads
// the result register. The parent table read, one parent per cycle, paces the
// walks. One request is in flight at a time. Reset and every element count
// write start a clearing pass that writes each entry with its own index;
// in_ready stays low meanwhile. A finished item waits in the output register
// while a new request is accepted and walked; if the receiver stalls, the
// sequencer holds in its final state until the output register frees.
`timescale 1ns / 1ps

`include "disjoint_set_union_find_macros.svh"

module disjoint_set_union_find #(
  parameter int unsigned ELEMENTS = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dsu_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dsu_pkg::out_t out_data,
  input  logic          cfg_we,
  input  dsu_pkg::cnt_t cfg_wdata
);

  // table depth is bounded by the reach of a 10-bit index
  localparam int unsigned DEPTH = (ELEMENTS < dsu_pkg::MAX_INDEXED) ? ELEMENTS
                                                                    : dsu_pkg::MAX_INDEXED;
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CAP = (ELEMENTS < 2047) ? ELEMENTS : 2047;
  localparam dsu_pkg::cnt_t ELEM_CAP  = dsu_pkg::cnt_t'(CAP);
  localparam dsu_pkg::cnt_t RESET_CNT = dsu_pkg::cnt_t'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);

  typedef logic [AW-1:0] ptr_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_WALK  = 5'b00100,
    S_COMP  = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t        state_r, state_nxt;
  dsu_pkg::cnt_t elements_r, elements_nxt;
  dsu_pkg::cnt_t live_r, live_nxt;
  ptr_t          clr_idx_r, clr_idx_nxt;
  dsu_pkg::in_t  req_r, req_nxt;
  ptr_t          top_r, top_nxt;
  ptr_t          start_r, start_nxt;
  ptr_t          node_r, node_nxt;
  ptr_t          rx_r, rx_nxt;
  ptr_t          ry_r, ry_nxt;
  logic          phase_r, phase_nxt;
  logic          bad_r, bad_nxt;
  logic          out_valid_r, out_valid_nxt;
  dsu_pkg::out_t out_data_r, out_data_nxt;

  // parent table
  ptr_t          parent_mem [DEPTH];
  ptr_t          rd_data_r;
  ptr_t          rd_addr;
  logic          we;
  ptr_t          wr_addr;
  ptr_t          wr_data;

  logic          root_done;
  logic          x_bad;
  logic          y_bad;
  logic          do_link;
  logic          fin_go;
  ptr_t          lo_root;
  ptr_t          hi_root;
  dsu_pkg::cnt_t cfg_clamped;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // element count write, clamped to one up to the lesser of ELEMENTS and 2047
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_clamped = dsu_pkg::cnt_t'(1);
    end else if (cfg_wdata > ELEM_CAP) begin
      cfg_clamped = ELEM_CAP;
    end else begin
      cfg_clamped = cfg_wdata;
    end
  end

  // range checks on an incoming item
  assign x_bad = ({1'b0, in_data.elem_x} >= elements_r);
  assign y_bad = (in_data.req_type != dsu_pkg::REQ_FIND) &&
                 ({1'b0, in_data.elem_y} >= elements_r);

  // link decision in the final state
  assign lo_root = (rx_r < ry_r) ? rx_r : ry_r;
  assign hi_root = (rx_r < ry_r) ? ry_r : rx_r;
  assign fin_go  = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign do_link = !bad_r && (req_r.req_type == dsu_pkg::REQ_MERGE) && (rx_r != ry_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    elements_nxt  = elements_r;
    live_nxt      = live_r;
    clr_idx_nxt   = clr_idx_r;
    req_nxt       = req_r;
    top_nxt       = top_r;
    start_nxt     = start_r;
    node_nxt      = node_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    phase_nxt     = phase_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    rd_addr       = top_r;
    we            = 1'b0;
    wr_addr       = node_r;
    wr_data       = top_r;
    root_done     = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        // each entry becomes its own root
        we      = 1'b1;
        wr_addr = clr_idx_r;
        wr_data = clr_idx_r;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + ptr_t'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          phase_nxt = 1'b0;
          rx_nxt    = '0;
          ry_nxt    = '0;
          if (x_bad || y_bad) begin
            bad_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            bad_nxt   = 1'b0;
            top_nxt   = in_data.elem_x[AW-1:0];
            start_nxt = in_data.elem_x[AW-1:0];
            rd_addr   = in_data.elem_x[AW-1:0];
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        // one parent hop per cycle until a self-parent is seen
        if (rd_data_r == top_r) begin
          if (start_r == top_r) begin
            root_done = 1'b1;
          end else begin
            node_nxt  = start_r;
            rd_addr   = start_r;
            state_nxt = S_COMP;
          end
        end else begin
          top_nxt = rd_data_r;
          rd_addr = rd_data_r;
        end
      end
      S_COMP: begin
        // point the current node at the root and move to its old parent
        we      = 1'b1;
        wr_addr = node_r;
        wr_data = top_r;
        if (rd_data_r == top_r) begin
          root_done = 1'b1;
        end else begin
          node_nxt = rd_data_r;
          rd_addr  = rd_data_r;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.bad_index = bad_r;
          out_data_nxt.same_set  = !bad_r && (req_r.req_type != dsu_pkg::REQ_FIND) &&
                                   (rx_r == ry_r);
          out_data_nxt.did_merge = do_link;
          out_data_nxt.set_count = live_r;
          out_data_nxt.root_x    = dsu_pkg::elem_t'(rx_r);
          out_data_nxt.root_y    = dsu_pkg::elem_t'(ry_r);
          if (do_link) begin
            we      = 1'b1;
            wr_addr = hi_root;
            wr_data = lo_root;
            out_data_nxt.root_x = dsu_pkg::elem_t'(lo_root);
            out_data_nxt.root_y = dsu_pkg::elem_t'(lo_root);
            if (live_r != '0) begin
              live_nxt               = live_r - dsu_pkg::cnt_t'(1);
              out_data_nxt.set_count = live_r - dsu_pkg::cnt_t'(1);
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a root has been found for the element in hand
    if (root_done) begin
      if (!phase_r) begin
        rx_nxt = top_r;
        if (req_r.req_type == dsu_pkg::REQ_FIND) begin
          state_nxt = S_FIN;
        end else begin
          phase_nxt = 1'b1;
          top_nxt   = req_r.elem_y[AW-1:0];
          start_nxt = req_r.elem_y[AW-1:0];
          rd_addr   = req_r.elem_y[AW-1:0];
          state_nxt = S_WALK;
        end
      end else begin
        ry_nxt    = top_r;
        state_nxt = S_FIN;
      end
    end

    // element count write restarts the forest
    if (cfg_we) begin
      elements_nxt = cfg_clamped;
      live_nxt     = cfg_clamped;
      clr_idx_nxt  = '0;
      state_nxt    = S_CLEAR;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      elements_r  <= RESET_CNT;
      live_r      <= RESET_CNT;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      bad_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      elements_r  <= elements_nxt;
      live_r      <= live_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      bad_r       <= bad_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    top_r      <= top_nxt;
    start_r    <= start_nxt;
    node_r     <= node_nxt;
    rx_r       <= rx_nxt;
    ry_r       <= ry_nxt;
    out_data_r <= out_data_nxt;
  end

  // parent table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      parent_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= parent_mem[rd_addr];
  end

  // checks
  `DSU_ASSERT_NOW(a_live_le_elems, 1'b1, live_r <= elements_r,
                  "live set count above element count")
  `DSU_ASSERT_NOW(a_walk_in_range, state_r == S_WALK, dsu_pkg::cnt_t'(top_r) < elements_r,
                  "parent walk left the element range")
  `DSU_ASSERT_NEXT(a_link_counts, fin_go && do_link && (live_r != '0) && !cfg_we,
                   live_r == $past(live_r) - dsu_pkg::cnt_t'(1),
                   "merge did not drop the set count by one")
  `DSU_ASSERT_NOW(a_bad_clean, out_valid_r && out_data_r.bad_index,
                  out_data_r.root_x == '0 && out_data_r.root_y == '0 &&
                  !out_data_r.did_merge && !out_data_r.same_set,
                  "out-of-range item carries results")
  `DSU_ASSERT_NOW(a_merge_roots, out_valid_r && out_data_r.did_merge,
                  !out_data_r.same_set && out_data_r.root_x == out_data_r.root_y,
                  "merged item roots disagree")

endmodule

[tb/sv/forest_sb_pkg.sv]
// scoreboard for the union-find testbench: forest predictor and result checking
`timescale 1ns / 1ps

package forest_sb_pkg;

  class forest_scoreboard;
    dsu_pkg::elem_t parent [dsu_pkg::MAX_INDEXED];
    dsu_pkg::cnt_t  live_sets;
    int unsigned    elem_count;
    dsu_pkg::out_t  results_due [$];
    int unsigned    errors = 0;
    int unsigned    requests = 0;
    int unsigned    merges = 0;
    int unsigned    out_of_range = 0;

    function new();
      rebuild(dsu_pkg::cnt_t'(dsu_pkg::MAX_INDEXED));
    endfunction

    // restart the forest as singletons; count clamped to one up to the table size
    function void rebuild(dsu_pkg::cnt_t value);
      if (value == 0) begin
        elem_count = 1;
      end else if (value > dsu_pkg::MAX_INDEXED) begin
        elem_count = dsu_pkg::MAX_INDEXED;
      end else begin
        elem_count = value;
      end
      for (int i = 0; i < dsu_pkg::MAX_INDEXED; i++) begin
        parent[i] = dsu_pkg::elem_t'(i);
      end
      live_sets = dsu_pkg::cnt_t'(elem_count);
    endfunction

    // walk up to the root, then point every node on the path straight at it
    function dsu_pkg::elem_t chase_root(dsu_pkg::elem_t node);
      dsu_pkg::elem_t top;
      dsu_pkg::elem_t next;
      int             steps;
      top = node;
      steps = 0;
      while (steps < dsu_pkg::MAX_INDEXED && parent[top] != top) begin
        top = parent[top];
        steps++;
      end
      steps = 0;
      while (node != top && steps < dsu_pkg::MAX_INDEXED) begin
        next = parent[node];
        parent[node] = top;
        node = next;
        steps++;
      end
      return top;
    endfunction

    // expected result of one request, updating the forest as the block would
    function dsu_pkg::out_t resolve_request(dsu_pkg::in_t item);
      dsu_pkg::out_t  res;
      bit             pair;
      dsu_pkg::elem_t rx;
      dsu_pkg::elem_t ry;
      res = '0;
      pair = (item.req_type != dsu_pkg::REQ_FIND);
      if (item.elem_x >= elem_count || (pair && item.elem_y >= elem_count)) begin
        res.bad_index = 1'b1;
      end else begin
        rx = chase_root(item.elem_x);
        if (pair) begin
          ry = chase_root(item.elem_y);
          res.same_set = (rx == ry);
          // larger root goes under the smaller one
          if (item.req_type == dsu_pkg::REQ_MERGE && rx != ry) begin
            if (rx < ry) begin
              parent[ry] = rx;
              ry = rx;
            end else begin
              parent[rx] = ry;
              rx = ry;
            end
            if (live_sets != 0) begin
              live_sets--;
            end
            res.did_merge = 1'b1;
          end
          res.root_y = ry;
        end
        res.root_x = rx;
      end
      res.set_count = live_sets;
      return res;
    endfunction

    function void note_request(dsu_pkg::in_t item);
      dsu_pkg::out_t res;
      res = resolve_request(item);
      results_due = {results_due, res};
      requests++;
      if (res.bad_index) begin
        out_of_range++;
      end
      if (res.did_merge) begin
        merges++;
      end
    endfunction

    function void compare_field(string name, logic [10:0] want, logic [10:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(dsu_pkg::out_t got);
      dsu_pkg::out_t want;
      if (results_due.size() == 0) begin
        $error("result item with no request outstanding");
        errors++;
        return;
      end
      want = results_due.pop_front();
      compare_field("root_x", dsu_pkg::cnt_t'(want.root_x), dsu_pkg::cnt_t'(got.root_x));
      compare_field("root_y", dsu_pkg::cnt_t'(want.root_y), dsu_pkg::cnt_t'(got.root_y));
      compare_field("same_set", dsu_pkg::cnt_t'(want.same_set),
                    dsu_pkg::cnt_t'(got.same_set));
      compare_field("did_merge", dsu_pkg::cnt_t'(want.did_merge),
                    dsu_pkg::cnt_t'(got.did_merge));
      compare_field("set_count", want.set_count, got.set_count);
      compare_field("bad_index", dsu_pkg::cnt_t'(want.bad_index),
                    dsu_pkg::cnt_t'(got.bad_index));
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction
  endclass

endpackage

[tb/sv/disjoint_set_union_find_tb.sv]
// testbench top for the union-find block: stimulus, handshakes and end-of-run checks
`timescale 1ns / 1ps

module disjoint_set_union_find_tb;

  localparam int unsigned HALF_PERIOD      = 6;
  localparam int unsigned STALL_LIMIT      = 20000;
  localparam int unsigned HOLD_OFF         = 400;
  localparam int unsigned RANDOM_PER_COUNT = 128;
  localparam dsu_pkg::cnt_t COUNT_PLAN [10] = '{11'd2, 11'd8, 11'd2047, 11'd16, 11'd64,
                                                11'd1, 11'd300, 11'd1025, 11'd37, 11'd1024};

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  dsu_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  dsu_pkg::out_t out_data;
  logic          cfg_we;
  dsu_pkg::cnt_t cfg_wdata;

  forest_sb_pkg::forest_scoreboard sb;
  int unsigned      idle_cycles = 0;
  int unsigned      counts_used = 0;
  bit               send_calm = 1'b0;
  bit               recv_calm = 1'b0;
  bit               hold_off_go = 1'b0;
  bit               hold_off_done = 1'b0;

  disjoint_set_union_find #(
    .ELEMENTS (dsu_pkg::MAX_INDEXED)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  // handshake monitor: note requests, check results, count quiet cycles
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid && in_ready) begin
        sb.note_request(in_data);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // mostly no gap, some short, a few long
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic dsu_pkg::in_t make_req(dsu_pkg::req_type_t kind, int unsigned x,
                                            int unsigned y);
    dsu_pkg::in_t item;
    item.req_type = kind;
    item.elem_x   = dsu_pkg::elem_t'(x);
    item.elem_y   = dsu_pkg::elem_t'(y);
    return item;
  endfunction

  // random request; indices mostly in range, now and then anywhere in the field
  function automatic dsu_pkg::in_t random_req(int unsigned n);
    int unsigned        r;
    int unsigned        x;
    int unsigned        y;
    dsu_pkg::req_type_t kind;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      kind = dsu_pkg::REQ_FIND;
    end else if (r < 62) begin
      kind = dsu_pkg::REQ_MERGE;
    end else if (r < 88) begin
      kind = dsu_pkg::REQ_CONN;
    end else begin
      kind = dsu_pkg::REQ_CONN3;
    end
    x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, n - 1);
    y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, n - 1);
    return make_req(kind, x, y);
  endfunction

  // offer one item after a random gap and hold it until accepted
  task automatic send_item(dsu_pkg::in_t item);
    int unsigned gap;
    gap = pick_gap(send_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // element count write once every result is back
  task automatic write_count(dsu_pkg::cnt_t value);
    in_valid <= 1'b0;
    // let the monitor note the last accepted item first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.rebuild(value);
    cfg_we <= 1'b0;
    counts_used++;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_go && !hold_off_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        gap = pick_gap(recv_calm);
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        do @(posedge clk); while (!out_valid);
      end
    end
  end

  // watchdog on cycles with no item moving either way
  initial begin
    wait (rst_n === 1'b1);
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $error("no item moved for %0d cycles", STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // main sequence
  initial begin
    int unsigned n;
    int unsigned step;
    int unsigned len;
    int unsigned base;
    sb        = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // full-size forest straight after reset
    send_item(make_req(dsu_pkg::REQ_FIND, 0, 1023));
    send_item(make_req(dsu_pkg::REQ_FIND, 1023, 0));
    send_item(make_req(dsu_pkg::REQ_MERGE, 1023, 0));
    send_item(make_req(dsu_pkg::REQ_MERGE, 5, 3));
    send_item(make_req(dsu_pkg::REQ_MERGE, 3, 5));
    send_item(make_req(dsu_pkg::REQ_CONN, 1023, 0));
    send_item(make_req(dsu_pkg::REQ_CONN3, 5, 1023));
    send_item(make_req(dsu_pkg::REQ_MERGE, 1023, 5));
    send_item(make_req(dsu_pkg::REQ_FIND, 5, 682));
    send_item(make_req(dsu_pkg::REQ_CONN, 682, 341));
    send_item(make_req(dsu_pkg::REQ_MERGE, 341, 682));

    // zero count taken as a single element; out-of-range on either index
    write_count(11'd0);
    send_item(make_req(dsu_pkg::REQ_FIND, 0, 1023));
    send_item(make_req(dsu_pkg::REQ_FIND, 1, 0));
    send_item(make_req(dsu_pkg::REQ_MERGE, 0, 1));
    send_item(make_req(dsu_pkg::REQ_MERGE, 1, 0));
    send_item(make_req(dsu_pkg::REQ_CONN, 0, 0));
    send_item(make_req(dsu_pkg::REQ_MERGE, 0, 0));
    send_item(make_req(dsu_pkg::REQ_CONN3, 512, 0));
    send_item(make_req(dsu_pkg::REQ_CONN3, 0, 0));

    // random phases, one per element count
    foreach (COUNT_PLAN[p]) begin
      write_count(COUNT_PLAN[p]);
      n         = sb.elem_count;
      send_calm = (p % 4 == 1) || (p == 6);
      recv_calm = (p % 4 == 1) || (p % 4 == 3);
      if (p == 6) begin
        hold_off_go = 1'b1;
      end
      step = 0;
      while (step < RANDOM_PER_COUNT) begin
        if (n >= 4 && $urandom_range(0, 99) < 6) begin
          // merges on descending roots build a long chain, then a find from its tail
          len  = $urandom_range(2, (n < 24) ? n - 1 : 24);
          base = $urandom_range(0, n - 1 - len);
          for (int k = len; k > 0; k--) begin
            send_item(make_req(dsu_pkg::REQ_MERGE, base + k, base + k - 1));
          end
          send_item(make_req(dsu_pkg::REQ_FIND, base + len, $urandom_range(0, 1023)));
          step += len + 1;
        end else begin
          send_item(random_req(n));
          step++;
        end
      end
    end

    // drain and settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("covered %0d requests over %0d element count writes: %0d merges, %0d out of range",
             sb.requests, counts_used, sb.merges, sb.out_of_range);
    $display("long receiver hold-off of %0d cycles %0s", HOLD_OFF,
             hold_off_done ? "completed" : "not reached");
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[disjoint_set_union_find.f]
+incdir+src
src/dsu_pkg.sv
src/disjoint_set_union_find.sv
tb/sv/forest_sb_pkg.sv
tb/sv/disjoint_set_union_find_tb.sv
